[hdl/s1h_pkg.sv]
// ----------------------------------------------------------------------------
// s1h_pkg
// Shared types, constants and helpers for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package s1h_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BLOCK_W    = 512;
    localparam int unsigned LEN_W      = 64;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned ROUND_W    = 7;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_CHAIN  = 5;
    localparam int unsigned IDX_W      = 3;

    localparam logic [POS_W-1:0]   LEN_POS   = POS_W'(56);
    localparam logic [BYTE_W-1:0]  PAD_BYTE  = 8'h80;

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    localparam logic [WORD_W-1:0] H_INIT [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } t_phase;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
    } t_vars;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

[hdl/s1h_round.sv]
// ----------------------------------------------------------------------------
// s1h_round
// One SHA-1 round: logic function, constant and five-way add.
// ----------------------------------------------------------------------------
module s1h_round (
    input  s1h_pkg::t_vars                 i_vars,
    input  logic [s1h_pkg::WORD_W-1:0]     i_w,
    input  s1h_pkg::t_phase                i_phase,
    output s1h_pkg::t_vars                 o_vars
);

    logic [s1h_pkg::WORD_W-1:0] f;
    logic [s1h_pkg::WORD_W-1:0] k;

    always_comb begin
        case (i_phase)
            s1h_pkg::PH_CH: begin
                f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
                k = s1h_pkg::K0;
            end
            s1h_pkg::PH_PAR1: begin
                f = i_vars.b ^ i_vars.c ^ i_vars.d;
                k = s1h_pkg::K1;
            end
            s1h_pkg::PH_MAJ: begin
                f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
                k = s1h_pkg::K2;
            end
            default: begin
                f = i_vars.b ^ i_vars.c ^ i_vars.d;
                k = s1h_pkg::K3;
            end
        endcase
    end

    always_comb begin
        o_vars.a = s1h_pkg::rotl(i_vars.a, 5) + f + i_vars.e + i_w + k;
        o_vars.b = i_vars.a;
        o_vars.c = s1h_pkg::rotl(i_vars.b, 30);
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

[hdl/sha1_byte_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit
// SHA-1 over a byte stream; a finish item pads and emits the 160-bit digest.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  input   | i_valid, o_ready, i_kind, i_data_byte     | in
//  output  | o_valid, i_ready, o_digest_word,          | out
//          | o_word_index, o_last_word                 |
//
//  A data item is absorbed while idle; the item filling a 64-byte block also
//  runs 80 rounds on the single shared round unit, then one chaining add. A
//  finish item feeds padding (9 to 72 bytes) one byte per cycle outside its
//  one or two compressions, then holds five digest words until each is taken.
//  Synchronous active-low reset restores the initial chaining words.
//  o_ready is high only while idle; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_kind,
    input  logic [s1h_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [s1h_pkg::WORD_W-1:0]       o_digest_word,
    output logic [s1h_pkg::IDX_W-1:0]        o_word_index,
    output logic                             o_last_word
);

    localparam int unsigned WW = s1h_pkg::WORD_W;
    localparam int unsigned BW = s1h_pkg::BLOCK_W;

    s1h_pkg::t_state               r_state, n_state;
    logic [s1h_pkg::ROUND_W-1:0]   r_t, n_t;
    logic [s1h_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [s1h_pkg::LEN_W-1:0]     r_len, n_len;
    logic [s1h_pkg::LEN_W-1:0]     r_lensh, n_lensh;
    logic                          r_pad80, n_pad80;
    logic                          r_lenph, n_lenph;
    logic                          r_fin, n_fin;
    logic [BW-1:0]                 r_blk, n_blk;
    s1h_pkg::t_vars                r_v, n_v;
    logic [WW-1:0]                 r_h [s1h_pkg::NUM_CHAIN];
    logic [WW-1:0]                 n_h [s1h_pkg::NUM_CHAIN];
    logic [s1h_pkg::IDX_W-1:0]     r_idx, n_idx;

    logic [WW-1:0]                 wt;
    s1h_pkg::t_phase               phase;
    s1h_pkg::t_vars                rnd_v;
    logic                          do_abs;
    logic [s1h_pkg::BYTE_W-1:0]    abs_byte;
    logic [s1h_pkg::POS_W-1:0]     pos_inc;

    always_comb begin
        if (r_t < s1h_pkg::ROUND_W'(16)) begin
            wt = r_blk[BW-1 -: WW];
        end else begin
            wt = s1h_pkg::rotl(r_blk[BW-1-13*WW -: WW] ^ r_blk[BW-1-8*WW -: WW] ^
                               r_blk[BW-1-2*WW -: WW] ^ r_blk[BW-1 -: WW], 1);
        end
        if (r_t < s1h_pkg::ROUND_W'(20)) begin
            phase = s1h_pkg::PH_CH;
        end else if (r_t < s1h_pkg::ROUND_W'(40)) begin
            phase = s1h_pkg::PH_PAR1;
        end else if (r_t < s1h_pkg::ROUND_W'(60)) begin
            phase = s1h_pkg::PH_MAJ;
        end else begin
            phase = s1h_pkg::PH_PAR2;
        end
    end

    s1h_round u_round (
        .i_vars  (r_v),
        .i_w     (wt),
        .i_phase (phase),
        .o_vars  (rnd_v)
    );

    assign pos_inc       = r_pos + s1h_pkg::POS_W'(1);
    assign o_ready       = (r_state == s1h_pkg::ST_IDLE);
    assign o_valid       = (r_state == s1h_pkg::ST_OUT);
    assign o_digest_word = r_h[0];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == s1h_pkg::IDX_W'(s1h_pkg::NUM_CHAIN - 1));

    always_comb begin
        n_state  = r_state;
        n_t      = r_t;
        n_pos    = r_pos;
        n_len    = r_len;
        n_lensh  = r_lensh;
        n_pad80  = r_pad80;
        n_lenph  = r_lenph;
        n_fin    = r_fin;
        n_blk    = r_blk;
        n_v      = r_v;
        n_h      = r_h;
        n_idx    = r_idx;
        do_abs   = 1'b0;
        abs_byte = '0;

        case (r_state)
            s1h_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (!i_kind) begin
                        do_abs   = 1'b1;
                        abs_byte = i_data_byte;
                        n_len    = r_len + s1h_pkg::LEN_W'(8);
                    end else begin
                        n_fin   = 1'b1;
                        n_lensh = r_len;
                        n_state = s1h_pkg::ST_PAD;
                    end
                end
            end
            s1h_pkg::ST_PAD: begin
                do_abs = 1'b1;
                if (!r_pad80) begin
                    abs_byte = s1h_pkg::PAD_BYTE;
                    n_pad80  = 1'b1;
                end else if (!r_lenph && r_pos != s1h_pkg::LEN_POS) begin
                    abs_byte = '0;
                end else begin
                    n_lenph  = 1'b1;
                    abs_byte = r_lensh[s1h_pkg::LEN_W-1 -: s1h_pkg::BYTE_W];
                    n_lensh  = {r_lensh[s1h_pkg::LEN_W-s1h_pkg::BYTE_W-1:0],
                                s1h_pkg::BYTE_W'(0)};
                end
            end
            s1h_pkg::ST_ROUND: begin
                n_v   = rnd_v;
                n_blk = {r_blk[BW-WW-1:0], wt};
                if (r_t == s1h_pkg::ROUND_W'(s1h_pkg::NUM_ROUNDS - 1)) begin
                    n_state = s1h_pkg::ST_FINAL;
                end else begin
                    n_t = r_t + s1h_pkg::ROUND_W'(1);
                end
            end
            s1h_pkg::ST_FINAL: begin
                n_h[0] = r_h[0] + r_v.a;
                n_h[1] = r_h[1] + r_v.b;
                n_h[2] = r_h[2] + r_v.c;
                n_h[3] = r_h[3] + r_v.d;
                n_h[4] = r_h[4] + r_v.e;
                if (!r_fin) begin
                    n_state = s1h_pkg::ST_IDLE;
                end else if (r_lenph) begin
                    n_idx   = '0;
                    n_state = s1h_pkg::ST_OUT;
                end else begin
                    n_state = s1h_pkg::ST_PAD;
                end
            end
            s1h_pkg::ST_OUT: begin
                if (i_ready) begin
                    if (o_last_word) begin
                        n_h     = s1h_pkg::H_INIT;
                        n_pos   = '0;
                        n_len   = '0;
                        n_pad80 = 1'b0;
                        n_lenph = 1'b0;
                        n_fin   = 1'b0;
                        n_state = s1h_pkg::ST_IDLE;
                    end else begin
                        n_h[0] = r_h[1];
                        n_h[1] = r_h[2];
                        n_h[2] = r_h[3];
                        n_h[3] = r_h[4];
                        n_h[4] = r_h[0];
                        n_idx  = r_idx + s1h_pkg::IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = s1h_pkg::ST_IDLE;
            end
        endcase

        if (do_abs) begin
            n_blk = {r_blk[BW-s1h_pkg::BYTE_W-1:0], abs_byte};
            n_pos = pos_inc;
            if (pos_inc == '0) begin
                n_t     = '0;
                n_v.a   = r_h[0];
                n_v.b   = r_h[1];
                n_v.c   = r_h[2];
                n_v.d   = r_h[3];
                n_v.e   = r_h[4];
                n_state = s1h_pkg::ST_ROUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s1h_pkg::ST_IDLE;
            r_t     <= '0;
            r_pos   <= '0;
            r_len   <= '0;
            r_pad80 <= 1'b0;
            r_lenph <= 1'b0;
            r_fin   <= 1'b0;
            r_idx   <= '0;
            r_h     <= s1h_pkg::H_INIT;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_pad80 <= n_pad80;
            r_lenph <= n_lenph;
            r_fin   <= n_fin;
            r_idx   <= n_idx;
            r_h     <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lensh <= n_lensh;
        r_blk   <= n_blk;
        r_v     <= n_v;
    end

endmodule
